// ===== sv/crcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame checker package
// Status codes, the result record and the byte-wide CRC update functions
// shared by the frame checker modules.
// ----------------------------------------------------------------------------
package crcfc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'h04c1_1db7;
    localparam int          M_TDATA_W = 144;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_BAD_MAGIC,
        STATUS_BAD_CRC,
        STATUS_BAD_SIZE
    } status_t;

    // Packed from the top bit down; status sits in the lowest bits.
    typedef struct packed {
        logic [11:0] frame_bytes;
        logic [31:0] received_crc;
        logic [31:0] computed_crc;
        logic [31:0] declared_size;
        logic [31:0] command_word;
        status_t     status;
    } result_t;

    function automatic logic [31:0] crc_table(input logic [7:0] idx);
        logic [31:0] t;
        t = {idx, 24'h000000};
        for (int j = 0; j < 8; j++) begin
            if (t[31]) begin
                t = {t[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                t = {t[30:0], 1'b0};
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] crc_feed(input logic [31:0] r, input logic [7:0] d);
        return {r[23:0], d} ^ crc_table(r[31:24]);
    endfunction

endpackage

// ===== sv/crcfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame checker input register
// Holds one received byte until the frame logic consumes it.
// ----------------------------------------------------------------------------
module crcfc_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       consume,
    output logic       in_valid,
    output logic [7:0] in_data,
    output logic       in_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (consume) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;
    assign in_last  = last_reg;

endmodule

// ===== sv/crcfc_frame.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame checker frame logic
// Tracks the header words, the running CRC and the trailing four bytes of
// the current frame, and forms the check result on the final byte.
// ----------------------------------------------------------------------------
module crcfc_frame #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                consume,
    input  logic [7:0]          in_data,
    input  logic                in_last,
    input  logic [31:0]         magic_word,
    output crcfc_pkg::result_t  result
);

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_FRAME_BYTES);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      magic_reg, magic_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      command_reg, command_next;
    logic [31:0]      tail_reg, tail_next;
    logic [31:0]      spec1_reg, spec1_next;
    logic [31:0]      spec2_reg, spec2_next;
    logic [31:0]      spec3_reg, spec3_next;
    logic [31:0]      feed_src;
    logic [31:0]      feed_out;
    logic [31:0]      crc_shift;
    logic [IDX_W-1:0] sat_count;
    logic             size_bad;

    always_comb begin
        if (idx_reg == IDX_W'(5)) begin
            feed_src = spec1_reg;
        end else if (idx_reg == IDX_W'(6)) begin
            feed_src = spec2_reg;
        end else if (idx_reg == IDX_W'(7)) begin
            feed_src = spec3_reg;
        end else begin
            feed_src = crc_reg;
        end
        feed_out  = crcfc_pkg::crc_feed(feed_src, in_data);
        crc_shift = {crc_reg[23:0], in_data};

        idx_next     = idx_reg;
        crc_next     = crc_reg;
        magic_next   = magic_reg;
        size_next    = size_reg;
        command_next = command_reg;
        spec1_next   = spec1_reg;
        spec2_next   = spec2_reg;
        spec3_next   = spec3_reg;

        if (idx_reg < MAX_IDX) begin
            if (idx_reg < IDX_W'(4)) begin
                magic_next[{idx_reg[1:0], 3'b000} +: 8] = in_data;
                crc_next = (idx_reg[1:0] == 2'd3) ? ~crc_shift : crc_shift;
            end else if (idx_reg < IDX_W'(8)) begin
                size_next[{idx_reg[1:0], 3'b000} +: 8] = in_data;
                if (idx_reg == IDX_W'(4)) begin
                    spec1_next = feed_out;
                end else if (idx_reg == IDX_W'(5)) begin
                    spec2_next = feed_out;
                end else if (idx_reg == IDX_W'(6)) begin
                    spec3_next = feed_out;
                end else if (size_next > 32'd11) begin
                    crc_next = feed_out;
                end else if (size_next > 32'd10) begin
                    crc_next = spec3_reg;
                end else if (size_next > 32'd9) begin
                    crc_next = spec2_reg;
                end else if (size_next > 32'd8) begin
                    crc_next = spec1_reg;
                end
            end else begin
                if (idx_reg < IDX_W'(12)) begin
                    command_next[{idx_reg[1:0], 3'b000} +: 8] = in_data;
                end
                if (33'(idx_reg) + 33'd4 < {1'b0, size_reg}) begin
                    crc_next = feed_out;
                end
            end
        end

        tail_next = {in_data, tail_reg[31:8]};
        if (idx_reg <= MAX_IDX) begin
            idx_next = idx_reg + IDX_W'(1);
        end

        size_bad = (idx_next < IDX_W'(8)) || (size_next < 32'd8) ||
                   (idx_next > MAX_IDX) || (32'(idx_next) < size_next);
        sat_count = (idx_next > MAX_IDX) ? MAX_IDX : idx_next;

        if (size_bad) begin
            result.status = crcfc_pkg::STATUS_BAD_SIZE;
        end else if (magic_next != magic_word) begin
            result.status = crcfc_pkg::STATUS_BAD_MAGIC;
        end else if (~crc_next != tail_next) begin
            result.status = crcfc_pkg::STATUS_BAD_CRC;
        end else begin
            result.status = crcfc_pkg::STATUS_OK;
        end
        result.command_word  = command_next;
        result.declared_size = size_next;
        result.computed_crc  = ~crc_next;
        result.received_crc  = tail_next;
        result.frame_bytes   = 12'(sat_count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            crc_reg     <= '0;
            magic_reg   <= '0;
            size_reg    <= '0;
            command_reg <= '0;
            tail_reg    <= '0;
        end else if (consume) begin
            if (in_last) begin
                idx_reg     <= '0;
                crc_reg     <= '0;
                magic_reg   <= '0;
                size_reg    <= '0;
                command_reg <= '0;
                tail_reg    <= '0;
            end else begin
                idx_reg     <= idx_next;
                crc_reg     <= crc_next;
                magic_reg   <= magic_next;
                size_reg    <= size_next;
                command_reg <= command_next;
                tail_reg    <= tail_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            spec1_reg <= spec1_next;
            spec2_reg <= spec2_next;
            spec3_reg <= spec3_next;
        end
    end

endmodule

// ===== sv/crcfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame checker output register
// Holds one check result until the downstream side takes it.
// ----------------------------------------------------------------------------
module crcfc_out_reg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  crcfc_pkg::result_t                result,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [crcfc_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int RES_W = $bits(crcfc_pkg::result_t);

    logic               valid_reg;
    logic               valid_next;
    crcfc_pkg::result_t result_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(crcfc_pkg::M_TDATA_W - RES_W){1'b0}}, result_reg};

endmodule

// ===== sv/crc32_frame_checker.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame checker
// Checks the magic word, declared size and CRC-32 of received frames.
//
//   Channel   Direction   Carries
//   s_        in          tdata: data_byte; tlast: frame_last
//   m_        out         tdata: one check result per frame
//   cfg_      in          data: magic_word
//
// One byte is accepted every cycle while no last byte waits; the result of
// a frame is loaded into the output register as its last byte leaves the
// input register. Each byte passes through an input register and one
// byte-wide CRC update. While a result waits in the output register, bytes
// of the next frame keep flowing, and only a further last byte waits. Reset
// clears the frame state, the magic word and both valid flags.
// ----------------------------------------------------------------------------
module crc32_frame_checker #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] data_byte
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [33:2] command_word, [65:34] declared_size,
    // [97:66] computed_crc, [129:98] received_crc, [141:130] frame_bytes
    output logic [crcfc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [31:0]                     cfg_data
);

    logic               in_valid;
    logic [7:0]         in_data;
    logic               in_last;
    logic               out_free;
    logic               consume;
    logic [31:0]        magic_word_reg;
    crcfc_pkg::result_t result;

    assign cfg_ready = 1'b1;
    assign consume   = in_valid && (!in_last || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            magic_word_reg <= cfg_data;
        end
    end

    crcfc_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .consume  (consume),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_last  (in_last)
    );

    crcfc_frame #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .consume    (consume),
        .in_data    (in_data),
        .in_last    (in_last),
        .magic_word (magic_word_reg),
        .result     (result)
    );

    crcfc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume && in_last),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/crcfc_checker.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame checker port checker
// Watches the ports of the frame checker for result consistency.
// ----------------------------------------------------------------------------
module crcfc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [crcfc_pkg::M_TDATA_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_short_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[141:130] < 12'd8) |->
        m_tdata[1:0] == crcfc_pkg::STATUS_BAD_SIZE)
        else $error("short frame not flagged as size error");

    a_ok_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == crcfc_pkg::STATUS_OK) |->
        m_tdata[97:66] == m_tdata[129:98])
        else $error("good status with mismatching CRC");

    a_ok_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != crcfc_pkg::STATUS_BAD_SIZE) |->
        m_tdata[65:34] >= 32'd8)
        else $error("declared size below minimum not flagged");

endmodule

bind crc32_frame_checker crcfc_checker u_crcfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
